### src/alfl_pkg.sv
`timescale 1ns / 1ps
// shared constants, operation and status codes for the linked list cell pool
// no dependencies

package alfl_pkg;

  localparam int unsigned CELL_COUNT_DEF = 64;
  localparam int unsigned HANDLE_W       = 7;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned STATUS_W       = 2;

  localparam logic [HANDLE_W-1:0] NULL_LINK = {HANDLE_W{1'b1}};

  localparam logic [OP_W-1:0] OP_CONS   = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_GET    = 2'd2;
  localparam logic [OP_W-1:0] OP_NEXT   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NULL  = 2'd2;

  // a handle names a cell only when it lies in 0 .. count-1
  function automatic logic is_cell(logic signed [HANDLE_W-1:0] h, int unsigned count);
    return (h >= 0) && (int'(h) < int'(count));
  endfunction

endpackage

### src/alfl_ram.sv
`timescale 1ns / 1ps
// simple dual port ram, one write and one registered read per cycle
// no dependencies

module alfl_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/array_linked_list_free_list.sv
`timescale 1ns / 1ps
// doubly linked list cell pool with free list: sequencer and link/key memories
// depends on alfl_pkg and alfl_ram

// One transaction at a time: start is taken while busy is low, and the result is
// shown for one cycle on result_valid_o, which cannot be held off. A null handle
// or an empty pool is answered without leaving idle; get and next pass through
// S_RSP, cons through S_C1 and S_C2, and delete through S_D1 to S_D4 before the
// result strobe. Busy drops in the cycle the result shows, so the next transaction
// may start then. These sequences are set by the single write port and single
// registered read port of the link memory, which holds the next links and prev
// links of all cells. After reset the block runs a pass that threads every cell
// onto the free list; busy stays high during it.

module array_linked_list_free_list
  import alfl_pkg::*;
#(
  parameter int unsigned CELL_COUNT = CELL_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            op_i,
  input  logic signed [HANDLE_W-1:0] handle_i,
  input  logic signed [KEY_W-1:0]    key_i,
  output logic                       result_valid_o,
  output logic signed [HANDLE_W-1:0] result_handle_o,
  output logic signed [KEY_W-1:0]    result_key_o,
  output logic [STATUS_W-1:0]        status_o
);

  localparam int unsigned AW = $clog2(CELL_COUNT);

  localparam logic SIDE_NEXT = 1'b0;
  localparam logic SIDE_PREV = 1'b1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_C1   = 3'd1;
  localparam logic [2:0] S_C2   = 3'd2;
  localparam logic [2:0] S_D1   = 3'd3;
  localparam logic [2:0] S_D2   = 3'd4;
  localparam logic [2:0] S_D3   = 3'd5;
  localparam logic [2:0] S_D4   = 3'd6;
  localparam logic [2:0] S_RSP  = 3'd7;

  function automatic logic [AW-1:0] idx(logic [HANDLE_W-1:0] h);
    return AW'(h);
  endfunction

  logic [2:0]          state_q, state_d;
  logic                init_q, init_d;
  logic [AW-1:0]       init_cnt_q, init_cnt_d;
  logic [HANDLE_W-1:0] free_head_q, free_head_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [HANDLE_W-1:0] h_q, h_d;
  logic [HANDLE_W-1:0] cell_q, cell_d;
  logic [HANDLE_W-1:0] p_q, p_d;
  logic [HANDLE_W-1:0] n_q, n_d;

  logic                res_valid_q, res_valid_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic [KEY_W-1:0]    res_key_q, res_key_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic                link_we;
  logic [AW:0]         link_waddr;
  logic [HANDLE_W-1:0] link_wdata;
  logic [AW:0]         link_raddr;
  logic [HANDLE_W-1:0] link_rdata;

  logic                key_we;
  logic [AW-1:0]       key_waddr;
  logic [KEY_W-1:0]    key_wdata;
  logic [AW-1:0]       key_raddr;
  logic [KEY_W-1:0]    key_rdata;

  logic accept;

  assign busy   = init_q || (state_q != S_IDLE);
  assign accept = start && !busy;

  // link memory: lower half next links, upper half prev links
  alfl_ram #(
    .DEPTH (2 * CELL_COUNT),
    .WIDTH (HANDLE_W),
    .AW    (AW + 1)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  alfl_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (KEY_W),
    .AW    (AW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  always_comb begin
    state_d      = state_q;
    init_d       = init_q;
    init_cnt_d   = init_cnt_q;
    free_head_d  = free_head_q;
    op_d         = op_q;
    h_d          = h_q;
    cell_d       = cell_q;
    p_d          = p_q;
    n_d          = n_q;
    res_valid_d  = 1'b0;
    res_handle_d = res_handle_q;
    res_key_d    = res_key_q;
    status_d     = status_q;
    link_we      = 1'b0;
    link_waddr   = '0;
    link_wdata   = '0;
    link_raddr   = '0;
    key_we       = 1'b0;
    key_waddr    = '0;
    key_wdata    = '0;
    key_raddr    = '0;

    if (init_q) begin
      // thread cell i onto cell i+1, last cell ends the free list
      link_we    = 1'b1;
      link_waddr = {SIDE_NEXT, init_cnt_q};
      if (init_cnt_q == AW'(CELL_COUNT - 1)) begin
        link_wdata = NULL_LINK;
        init_d     = 1'b0;
      end else begin
        link_wdata = HANDLE_W'({1'b0, init_cnt_q} + 1'b1);
      end
      init_cnt_d = init_cnt_q + 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_d = op_i;
            if (op_i == OP_CONS) begin
              if (!is_cell(free_head_q, CELL_COUNT)) begin
                res_valid_d  = 1'b1;
                res_handle_d = NULL_LINK;
                res_key_d    = '0;
                status_d     = ST_EMPTY;
              end else begin
                link_raddr = {SIDE_NEXT, idx(free_head_q)};
                link_we    = 1'b1;
                link_waddr = {SIDE_PREV, idx(free_head_q)};
                link_wdata = NULL_LINK;
                key_we     = 1'b1;
                key_waddr  = idx(free_head_q);
                key_wdata  = key_i;
                cell_d     = free_head_q;
                h_d        = is_cell(handle_i, CELL_COUNT) ? handle_i : NULL_LINK;
                state_d    = S_C1;
              end
            end else if (!is_cell(handle_i, CELL_COUNT)) begin
              res_valid_d  = 1'b1;
              res_handle_d = NULL_LINK;
              res_key_d    = (op_i == OP_GET) ? {KEY_W{1'b1}} : '0;
              status_d     = ST_NULL;
            end else begin
              h_d = handle_i;
              unique case (op_i)
                OP_DELETE: begin
                  link_raddr = {SIDE_PREV, idx(handle_i)};
                  state_d    = S_D1;
                end
                OP_GET: begin
                  key_raddr = idx(handle_i);
                  state_d   = S_RSP;
                end
                OP_NEXT: begin
                  link_raddr = {SIDE_NEXT, idx(handle_i)};
                  state_d    = S_RSP;
                end
                default: begin
                  state_d = S_IDLE;
                end
              endcase
            end
          end
        end
        S_C1: begin
          free_head_d = link_rdata;
          link_we     = 1'b1;
          link_waddr  = {SIDE_NEXT, idx(cell_q)};
          link_wdata  = h_q;
          state_d     = S_C2;
        end
        S_C2: begin
          if (is_cell(h_q, CELL_COUNT)) begin
            link_we    = 1'b1;
            link_waddr = {SIDE_PREV, idx(h_q)};
            link_wdata = cell_q;
          end
          res_valid_d  = 1'b1;
          res_handle_d = cell_q;
          res_key_d    = '0;
          status_d     = ST_OK;
          state_d      = S_IDLE;
        end
        S_D1: begin
          p_d        = link_rdata;
          link_raddr = {SIDE_NEXT, idx(h_q)};
          state_d    = S_D2;
        end
        S_D2: begin
          n_d = link_rdata;
          if (is_cell(p_q, CELL_COUNT)) begin
            link_we    = 1'b1;
            link_waddr = {SIDE_NEXT, idx(p_q)};
            link_wdata = link_rdata;
          end
          state_d = S_D3;
        end
        S_D3: begin
          if (is_cell(n_q, CELL_COUNT)) begin
            link_we    = 1'b1;
            link_waddr = {SIDE_PREV, idx(n_q)};
            link_wdata = p_q;
          end
          state_d = S_D4;
        end
        S_D4: begin
          // push the freed cell onto the free list
          link_we      = 1'b1;
          link_waddr   = {SIDE_NEXT, idx(h_q)};
          link_wdata   = free_head_q;
          free_head_d  = h_q;
          res_valid_d  = 1'b1;
          res_handle_d = NULL_LINK;
          res_key_d    = '0;
          status_d     = ST_OK;
          state_d      = S_IDLE;
        end
        S_RSP: begin
          res_valid_d = 1'b1;
          status_d    = ST_OK;
          if (op_q == OP_GET) begin
            res_handle_d = NULL_LINK;
            res_key_d    = key_rdata;
          end else begin
            res_handle_d = link_rdata;
            res_key_d    = '0;
          end
          state_d = S_IDLE;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      init_q      <= 1'b1;
      init_cnt_q  <= '0;
      free_head_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      init_cnt_q  <= init_cnt_d;
      free_head_q <= free_head_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    h_q          <= h_d;
    cell_q       <= cell_d;
    p_q          <= p_d;
    n_q          <= n_d;
    res_handle_q <= res_handle_d;
    res_key_q    <= res_key_d;
    status_q     <= status_d;
  end

  assign result_valid_o  = res_valid_q;
  assign result_handle_o = res_handle_q;
  assign result_key_o    = res_key_q;
  assign status_o        = status_q;

  // no result while the free list is being built
  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> !result_valid_o)
    else $error("result strobe during free list build");

  // a multi-cycle operation shows its result only once it is back in idle
  a_no_result_mid_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !result_valid_o)
    else $error("result strobe while an operation is in flight");

  a_null_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_i != OP_CONS) && !is_cell(handle_i, CELL_COUNT))
      |=> (result_valid_o && (status_o == ST_NULL)))
    else $error("null handle not answered in one cycle");

  a_pool_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_i == OP_CONS) && !is_cell(free_head_q, CELL_COUNT))
      |=> (result_valid_o && (status_o == ST_EMPTY) && (result_handle_o == NULL_LINK)))
    else $error("empty pool not reported on cons");

endmodule
